// File: hdl/smaa_pkg.sv
`default_nettype none
package smaa_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_SENSORS = 64;
    localparam int DEF_WINDOW      = 5;

    // field widths
    localparam int ID_W   = 16;
    localparam int TEMP_W = 16;
    localparam int ST_W   = 3;

    // configuration registers
    localparam logic CFG_MIN = 1'b0;
    localparam logic CFG_MAX = 1'b1;
    localparam logic signed [TEMP_W-1:0] MIN_RESET = 16'sd2560;
    localparam logic signed [TEMP_W-1:0] MAX_RESET = 16'sd5120;

    typedef enum logic [ST_W-1:0] {
        ST_REGISTERED = 3'd0,
        ST_FULL       = 3'd1,
        ST_UNKNOWN    = 3'd2,
        ST_IN_RANGE   = 3'd3,
        ST_COLD       = 3'd4,
        ST_HOT        = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_DECIDE,
        S_MRD,
        S_MUPD,
        S_HRD,
        S_HACC,
        S_DIVI,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_item;
        logic    scan_cmp;
        logic    reg_write;
        logic    set_st;
        status_t st;
        logic    meta_upd;
        logic    hist_acc;
        logic    div_start;
        logic    div_step;
        logic    fin_avg;
        logic    out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic func;
        logic hit;
        logic scan_last;
        logic match;
        logic free_found;
        logic hist_last;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: hdl/smaa_ram.sv
`default_nettype none
module smaa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hdl/smaa_ctrl.sv
`default_nettype none
module smaa_ctrl
    import smaa_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    output cmd_t       cmd,
    input  wire stat_t stat
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_SRD;
            S_SRD:    state_next = S_SCMP;
            S_SCMP: begin
                if (stat.hit || stat.scan_last) state_next = S_DECIDE;
                else                             state_next = S_SRD;
            end
            S_DECIDE: begin
                if (stat.func && stat.match) state_next = S_MRD;
                else                         state_next = S_OUT;
            end
            S_MRD:    state_next = S_MUPD;
            S_MUPD:   state_next = S_HRD;
            S_HRD:    state_next = S_HACC;
            S_HACC: begin
                if (stat.hist_last) state_next = S_DIVI;
                else                state_next = S_HRD;
            end
            S_DIVI:   state_next = S_DIV;
            S_DIV:    if (stat.div_last) state_next = S_FIN;
            S_FIN:    state_next = S_OUT;
            S_OUT:    if (stat.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        cmd.st   = ST_REGISTERED;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            S_SCMP: cmd.scan_cmp = 1'b1;
            S_DECIDE: begin
                if (!stat.func) begin
                    cmd.set_st = 1'b1;
                    if (stat.match || stat.free_found) begin
                        cmd.reg_write = 1'b1;
                        cmd.st        = ST_REGISTERED;
                    end else begin
                        cmd.st = ST_FULL;
                    end
                end else if (!stat.match) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_UNKNOWN;
                end
            end
            S_MUPD:  cmd.meta_upd  = 1'b1;
            S_HACC:  cmd.hist_acc  = 1'b1;
            S_DIVI:  cmd.div_start = 1'b1;
            S_DIV:   cmd.div_step  = 1'b1;
            S_FIN:   cmd.fin_avg   = 1'b1;
            S_OUT:   cmd.out_load  = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/smaa_dpath.sv
`default_nettype none
module smaa_dpath
    import smaa_pkg::*;
#(
    parameter int MAX_SENSORS = DEF_MAX_SENSORS,
    parameter int WINDOW      = DEF_WINDOW
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [47:0]              s_tdata,
    input  wire logic                     s_tuser,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [47:0]              m_tdata,
    output logic      [ST_W-1:0]          m_tuser,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_index,
    input  wire logic [TEMP_W-1:0]        cfg_data,
    input  wire cmd_t                     cmd,
    output stat_t                         stat
);

    localparam int IDXW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int KW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SW   = TEMP_W + CW;
    localparam int BW   = $clog2(SW);
    localparam int HD   = MAX_SENSORS << KW;
    localparam int MW   = KW + CW;

    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_SENSORS - 1);
    localparam logic [KW-1:0]   LAST_WP  = KW'(WINDOW - 1);
    localparam logic [CW-1:0]   WIN_C    = CW'(WINDOW);
    localparam logic [BW-1:0]   LAST_BIT = BW'(SW - 1);

    // item and thresholds
    logic                     func_reg;
    logic [ID_W-1:0]          sid_reg, room_in_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [TEMP_W-1:0] min_reg, max_reg;

    // lookup state
    logic [MAX_SENSORS-1:0]   valid_reg;
    logic [IDXW-1:0]          scan_reg, idx_reg, free_reg;
    logic                     match_reg, free_found_reg;

    // averaging state
    logic [KW-1:0]            k_reg;
    logic [CW-1:0]            cnt_reg;
    logic [ID_W-1:0]          room_reg;
    logic signed [SW-1:0]     sum_reg;
    logic [SW-1:0]            mag_reg;
    logic [CW-1:0]            rem_reg;
    logic [BW-1:0]            bit_reg;
    logic                     neg_reg;

    // result
    status_t                  st_reg;
    logic [ID_W-1:0]          room_res_reg;
    logic signed [TEMP_W-1:0] avg_res_reg;
    logic                     m_valid_reg;
    status_t                  m_st_reg;
    logic [ID_W-1:0]          m_sid_reg, m_room_reg;
    logic [TEMP_W-1:0]        m_avg_reg;

    // memories
    logic [ID_W-1:0]          sens_rdata, room_rdata;
    logic [MW-1:0]            meta_rdata, meta_wdata;
    logic [TEMP_W-1:0]        hist_rdata;
    logic [IDXW-1:0]          reg_idx;
    logic                     meta_we;
    logic [KW-1:0]            wp_cur, wp_nxt;
    logic [CW-1:0]            fc_cur, fc_new;

    assign reg_idx = match_reg ? idx_reg : free_reg;

    smaa_ram #(.WIDTH(ID_W), .DEPTH(MAX_SENSORS)) u_sens (
        .aclk(aclk), .we(cmd.reg_write), .waddr(reg_idx), .wdata(sid_reg),
        .raddr(scan_reg), .rdata(sens_rdata)
    );

    smaa_ram #(.WIDTH(ID_W), .DEPTH(MAX_SENSORS)) u_room (
        .aclk(aclk), .we(cmd.reg_write), .waddr(reg_idx), .wdata(room_in_reg),
        .raddr(idx_reg), .rdata(room_rdata)
    );

    // meta entry: {fill count, write position}
    assign fc_cur = meta_rdata[MW-1:KW];
    assign wp_cur = (meta_rdata[KW-1:0] > LAST_WP) ? '0 : meta_rdata[KW-1:0];
    assign wp_nxt = (wp_cur == LAST_WP) ? '0 : wp_cur + 1'b1;
    assign fc_new = (fc_cur < WIN_C) ? fc_cur + 1'b1 : fc_cur;
    assign meta_we    = cmd.reg_write || cmd.meta_upd;
    assign meta_wdata = cmd.reg_write ? '0 : {fc_new, wp_nxt};

    smaa_ram #(.WIDTH(MW), .DEPTH(MAX_SENSORS)) u_meta (
        .aclk(aclk), .we(meta_we), .waddr(reg_idx), .wdata(meta_wdata),
        .raddr(idx_reg), .rdata(meta_rdata)
    );

    smaa_ram #(.WIDTH(TEMP_W), .DEPTH(HD)) u_hist (
        .aclk(aclk), .we(cmd.meta_upd), .waddr({idx_reg, wp_cur}), .wdata(temp_reg),
        .raddr({idx_reg, k_reg}), .rdata(hist_rdata)
    );

    // divider step: restoring, one quotient bit per cycle
    logic [CW:0] rem_sh, rem_dif;
    logic        ge;
    assign rem_sh  = {rem_reg, mag_reg[SW-1]};
    assign ge      = rem_sh >= {1'b0, cnt_reg};
    assign rem_dif = rem_sh - {1'b0, cnt_reg};

    logic signed [TEMP_W-1:0] avg_new;
    assign avg_new = neg_reg ? -$signed(mag_reg[TEMP_W-1:0]) : $signed(mag_reg[TEMP_W-1:0]);

    logic hit;
    assign hit = valid_reg[scan_reg] && (sens_rdata == sid_reg);

    // status to controller
    always_comb begin
        stat.func       = func_reg;
        stat.hit        = hit;
        stat.scan_last  = scan_reg == LAST_IDX;
        stat.match      = match_reg;
        stat.free_found = free_found_reg;
        stat.hist_last  = (CW'(k_reg) + 1'b1) == cnt_reg;
        stat.div_last   = bit_reg == LAST_BIT;
        stat.out_free   = !m_valid_reg || m_tready;
    end

    // thresholds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_MIN) min_reg <= cfg_data;
            else                      max_reg <= cfg_data;
        end
    end

    // item capture and table scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            scan_reg       <= '0;
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                scan_reg       <= '0;
                match_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (cmd.scan_cmp) begin
                if (hit) begin
                    match_reg <= 1'b1;
                end else if (!valid_reg[scan_reg] && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
                if (scan_reg != LAST_IDX) scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.reg_write) valid_reg[reg_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            func_reg    <= s_tuser;
            sid_reg     <= s_tdata[15:0];
            room_in_reg <= s_tdata[31:16];
            temp_reg    <= s_tdata[47:32];
        end
        if (cmd.scan_cmp) begin
            if (hit) idx_reg <= scan_reg;
            if (!valid_reg[scan_reg] && !free_found_reg) free_reg <= scan_reg;
        end
    end

    // ring update, sum and divide
    always_ff @(posedge aclk) begin
        if (cmd.meta_upd) begin
            cnt_reg  <= fc_new;
            room_reg <= room_rdata;
            k_reg    <= '0;
            sum_reg  <= '0;
        end
        if (cmd.hist_acc) begin
            sum_reg <= sum_reg + SW'($signed(hist_rdata));
            k_reg   <= k_reg + 1'b1;
        end
        if (cmd.div_start) begin
            neg_reg <= sum_reg[SW-1];
            mag_reg <= sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
            rem_reg <= '0;
            bit_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? rem_dif[CW-1:0] : rem_sh[CW-1:0];
            mag_reg <= {mag_reg[SW-2:0], ge};
            bit_reg <= bit_reg + 1'b1;
        end
    end

    // result staging
    always_ff @(posedge aclk) begin
        if (cmd.set_st) begin
            st_reg       <= cmd.st;
            room_res_reg <= (cmd.st == ST_REGISTERED) ? room_in_reg : '0;
            avg_res_reg  <= '0;
        end
        if (cmd.fin_avg) begin
            room_res_reg <= room_reg;
            avg_res_reg  <= avg_new;
            if (avg_new < min_reg)      st_reg <= ST_COLD;
            else if (avg_new > max_reg) st_reg <= ST_HOT;
            else                        st_reg <= ST_IN_RANGE;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_st_reg   <= st_reg;
            m_sid_reg  <= sid_reg;
            m_room_reg <= room_res_reg;
            m_avg_reg  <= avg_res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_avg_reg, m_room_reg, m_sid_reg};
    assign m_tuser  = m_st_reg;

endmodule
`default_nettype wire

// File: hdl/sensor_moving_average_alarm.sv
// Each table entry is scanned in turn (stopping at the matching entry); then a registration,
// a full table or an unknown id goes straight to the output, while a reading updates its ring,
// sums the filled entries and divides over 16+clog2(WINDOW+1) bits; the divider retires one bit per cycle.
// Throughput: one item at a time; the next beat is taken once the result is in the output register.
// Reset: aresetn (synchronous, active low) empties the sensor table and restores both thresholds.
`default_nettype none
module sensor_moving_average_alarm
    import smaa_pkg::*;
#(
    parameter int MAX_SENSORS = DEF_MAX_SENSORS,
    parameter int WINDOW      = DEF_WINDOW
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // sensor_id, room_id, temperature
    input  wire logic              s_tuser,   // func
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [47:0]       m_tdata,   // sensor_out, room_out, average
    output logic      [ST_W-1:0]   m_tuser,   // status
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [TEMP_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    smaa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .cmd(cmd), .stat(stat)
    );

    smaa_dpath #(.MAX_SENSORS(MAX_SENSORS), .WINDOW(WINDOW)) u_dpath (
        .aclk(aclk), .aresetn(aresetn), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .stat(stat)
    );

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import smaa_pkg::*;

    localparam int N_SLOTS = DEF_MAX_SENSORS;
    localparam int RING    = DEF_WINDOW;

    typedef struct {
        status_t           status;
        logic [15:0]       sensor;
        logic [15:0]       room;
        logic signed [15:0] average;
    } alarm_t;

    int fail_count = 0;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Predicts the alarm for each accepted beat and checks outgoing beats in order.
    class alarm_board;
        logic signed [15:0] lo_limit = MIN_RESET;
        logic signed [15:0] hi_limit = MAX_RESET;
        bit          used [N_SLOTS];
        logic [15:0] ids  [N_SLOTS];
        logic [15:0] rooms[N_SLOTS];
        logic signed [15:0] ring[N_SLOTS][RING];
        int          wpos [N_SLOTS];
        int          fill [N_SLOTS];
        alarm_t      pending[$];
        int          n_status[6];

        function void note_input(logic func, logic [15:0] sid, logic [15:0] room,
                                 logic signed [15:0] temp);
            alarm_t e;
            int slot;
            int sum;
            int avg;
            slot = -1;
            for (int i = 0; i < N_SLOTS; i++)
                if (slot < 0 && used[i] && ids[i] == sid) slot = i;
            e.sensor = sid;
            e.room = '0;
            e.average = '0;
            if (func == 1'b0) begin
                if (slot < 0)
                    for (int i = 0; i < N_SLOTS; i++)
                        if (slot < 0 && !used[i]) slot = i;
                if (slot < 0) begin
                    e.status = ST_FULL;
                end else begin
                    used[slot] = 1; ids[slot] = sid; rooms[slot] = room;
                    wpos[slot] = 0; fill[slot] = 0;
                    e.status = ST_REGISTERED;
                    e.room = room;
                end
            end else if (slot < 0) begin
                e.status = ST_UNKNOWN;
            end else begin
                ring[slot][wpos[slot]] = temp;
                wpos[slot] = (wpos[slot] + 1) % RING;
                if (fill[slot] < RING) fill[slot]++;
                sum = 0;
                for (int k = 0; k < fill[slot]; k++) sum += int'(ring[slot][k]);
                avg = sum / fill[slot];
                e.average = avg[15:0];
                e.room = rooms[slot];
                if (avg < int'(lo_limit)) e.status = ST_COLD;
                else if (avg > int'(hi_limit)) e.status = ST_HOT;
                else e.status = ST_IN_RANGE;
            end
            pending.push_back(e);
        endfunction

        task check_result(logic [2:0] st, logic [47:0] data);
            alarm_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat status %0d data %h", st, data));
                return;
            end
            e = pending.pop_front();
            if (st < 6) n_status[st]++;
            if (st !== e.status)
                report($sformatf("status %0d, want %0d", st, e.status));
            if (data[15:0] !== e.sensor)
                report($sformatf("sensor %h, want %h", data[15:0], e.sensor));
            if (data[31:16] !== e.room)
                report($sformatf("room %h, want %h", data[31:16], e.room));
            if (data[47:32] !== e.average)
                report($sformatf("average %h, want %h", data[47:32], e.average));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 0;
    logic        cfg_index = CFG_MIN;
    logic [15:0] cfg_data = '0;

    alarm_board board = new();
    int hold_off = 0;   // long receiver stall, counted in the sink process
    bit stim_done = 0;
    int n_sent = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    sensor_moving_average_alarm u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_we, .cfg_index, .cfg_data
    );

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 4) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // Send one beat; predict on acceptance. Valid stays up for a back-to-back beat.
    task automatic send(input logic func, input logic [15:0] sid, input logic [15:0] room,
                        input logic [15:0] temp, input bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= func;
        s_tdata  <= {temp, room, sid};
        do @(posedge aclk); while (!s_tready);
        board.note_input(func, sid, room, temp);
        n_sent++;
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == CFG_MIN) board.lo_limit = val; else board.hi_limit = val;
        @(posedge aclk);
    endtask

    // Drain, then give the block time to settle before touching config.
    task automatic wait_idle();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Result sink with random stalls plus an optional long hold-off.
    initial begin
        int g;
        g = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 0;
            end else if (g > 0) begin
                g--;
                m_tready <= 0;
            end else if (stim_done || $urandom_range(0, 3) != 0) begin
                m_tready <= 1;
            end else begin
                g = pick_gap();
                m_tready <= 0;
            end
        end
    end

    logic [15:0] pool[8];

    initial begin
        int ph;
        logic [15:0] sid;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, unknown ids, re-registration, id zero, full table.
        send(1, 16'h0000, 16'h1234, 16'h0100, 0);
        send(0, 16'h0000, 16'hFFFF, 16'hFFFF, 0);
        send(1, 16'h0000, 16'h0000, 16'h7FFF, 0);
        send(1, 16'h0000, 16'h0000, 16'h7FFF, 0);
        send(1, 16'h0000, 16'h0000, 16'h8000, 0);
        send(1, 16'h0000, 16'hFFFF, 16'h8000, 0);
        send(1, 16'h0000, 16'h0000, 16'h0A00, 0);
        send(1, 16'h0000, 16'h0000, 16'h1400, 0);
        send(0, 16'h0000, 16'hAAAA, 16'h0000, 0);
        send(1, 16'h0000, 16'h0000, 16'h1400, 0);
        send(1, 16'h0000, 16'h0000, 16'h0A00, 0);
        send(0, 16'hFFFF, 16'h5555, 16'h0000, 0);
        send(1, 16'hFFFF, 16'h0000, 16'hFFFF, 0);
        send(1, 16'hFFFE, 16'h0000, 16'h0001, 0);
        for (int i = 1; i < N_SLOTS; i++) send(0, 16'(32'h1000 + i), 16'(i), 16'h0000, 0);
        send(0, 16'hBEEF, 16'h0001, 16'h0000, 0);
        send(0, 16'h1001, 16'h0777, 16'h0000, 0);
        send(1, 16'h1001, 16'h0000, 16'hFF80, 0);

        // Backpressure: stall the sink while the source keeps offering.
        hold_off = 300;
        for (int i = 0; i < 6; i++) send(1, 16'h1002, 16'h0000, rnd16(), 0);
        wait_idle();

        // Crossed limits and extremes, then random limits per phase.
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_MIN, 16'h0500); write_cfg(CFG_MAX, 16'hFB00); end
                1: begin write_cfg(CFG_MIN, 16'h8000); write_cfg(CFG_MAX, 16'h7FFF); end
                2: begin write_cfg(CFG_MIN, 16'h7FFF); write_cfg(CFG_MAX, 16'h8000); end
                default: begin
                    write_cfg(CFG_MIN, 16'($urandom_range(0, 16'h0C00) - 16'h0400));
                    write_cfg(CFG_MAX, 16'($urandom_range(16'h0800, 16'h1800)));
                end
            endcase
            // Re-register a small working set, then mostly readings.
            for (int i = 0; i < 8; i++) begin
                pool[i] = (i < 4) ? 16'(32'h1000 + $urandom_range(1, N_SLOTS - 1)) : rnd16();
                send(0, pool[i], rnd16(), rnd16(), 1);
            end
            for (int n = 0; n < 80; n++) begin
                sid = pool[$urandom_range(0, 7)];
                case ($urandom_range(0, 19))
                    0:       send(0, sid, rnd16(), rnd16(), 1);
                    1:       send(1, rnd16(), rnd16(), rnd16(), 1);
                    2:       send(0, rnd16(), rnd16(), rnd16(), 1);
                    3, 4:    send(1, sid, rnd16(), rnd16(), 1);
                    default: send(1, sid, rnd16(), 16'($urandom_range(0, 16'h1E00)), 1);
                endcase
            end
            wait_idle();
        end

        stim_done = 1;
        wait_idle();
        $display("Covered %0d beats: registered %0d, full %0d, unknown %0d",
                 n_sent, board.n_status[0], board.n_status[1], board.n_status[2]);
        $display("  in range %0d, too cold %0d, too hot %0d, over six limit settings",
                 board.n_status[3], board.n_status[4], board.n_status[5]);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
